>>> rtl/core/sxe_pkg.sv
package sxe_pkg;

    // Field widths of the token and result items.
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int FRAC_W = 16;

    // Default stack depth handed to the top level.
    localparam int STACK_DEPTH_DEF = 16;

    // Quotient bits produced by the restoring divider, one per cycle.
    localparam int DIV_STEPS = DATA_W + FRAC_W;

    // Token kinds.
    localparam logic [OP_W-1:0] OP_NUM = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_ONE   = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

    // Saturation bounds of Q16.16.
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_alu_req;

endpackage

>>> rtl/core/sxe_stack.sv
module sxe_stack #(
    parameter int DEPTH = sxe_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [sxe_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr_a,
    input  logic [AW-1:0]             i_raddr_b,
    output logic [sxe_pkg::DATA_W-1:0] o_rdata_a,
    output logic [sxe_pkg::DATA_W-1:0] o_rdata_b
);

    logic [sxe_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [sxe_pkg::DATA_W-1:0] r_rdata_a;
    logic [sxe_pkg::DATA_W-1:0] r_rdata_b;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports, used together to fetch both operands.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/core/sxe_alu.sv
module sxe_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sxe_pkg::t_alu_req          i_req,
    input  logic [sxe_pkg::DATA_W-1:0] i_lhs,
    input  logic [sxe_pkg::DATA_W-1:0] i_rhs,
    output logic                       o_done,
    output logic [sxe_pkg::DATA_W-1:0] o_result
);

    localparam int DW  = sxe_pkg::DATA_W;
    localparam int QW  = sxe_pkg::DIV_STEPS;
    localparam int FW  = sxe_pkg::FRAC_W;
    localparam int CNW = $clog2(QW);
    localparam int MW  = 2 * DW - FW + 1;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIN  = 2'd3;

    logic [1:0]        r_state;
    logic              r_done;
    logic [DW-1:0]     r_result;
    logic [2*DW-1:0]   r_prod;
    logic [QW-1:0]     r_dvd;
    logic [DW-1:0]     r_dvs;
    logic [DW-1:0]     r_rem;
    logic [CNW-1:0]    r_cnt;
    logic              r_neg;

    logic [DW:0]       w_sum;
    logic [DW:0]       w_diff;
    logic [MW-1:0]     w_mq;
    logic              w_rnd;
    logic [DW-1:0]     w_mul_res;
    logic [DW:0]       w_shift;
    logic [DW:0]       w_trial;
    logic              w_qbit;
    logic [DW-1:0]     w_div_res;

    // Clamp a 33-bit sum into the Q16.16 range.
    function automatic logic [DW-1:0] sat33(input logic [DW:0] s);
        if (s[DW] != s[DW-1]) begin
            sat33 = s[DW] ? sxe_pkg::Q_MIN : sxe_pkg::Q_MAX;
        end else begin
            sat33 = s[DW-1:0];
        end
    endfunction

    // Magnitude of a signed word as an unsigned word.
    function automatic logic [DW-1:0] abs32(input logic [DW-1:0] x);
        abs32 = x[DW-1] ? (~x + DW'(1)) : x;
    endfunction

    // Add and subtract with one extra bit for overflow detection.
    assign w_sum  = {i_lhs[DW-1], i_lhs} + {i_rhs[DW-1], i_rhs};
    assign w_diff = {i_lhs[DW-1], i_lhs} - {i_rhs[DW-1], i_rhs};

    // Product scaled down by 2^16, truncating toward zero, then saturated.
    assign w_rnd = r_prod[2*DW-1] && (r_prod[FW-1:0] != '0);
    assign w_mq  = {r_prod[2*DW-1], r_prod[2*DW-1:FW]} + MW'(w_rnd);
    always_comb begin
        if (w_mq[MW-1:DW-1] == '0 || w_mq[MW-1:DW-1] == '1) begin
            w_mul_res = w_mq[DW-1:0];
        end else begin
            w_mul_res = w_mq[MW-1] ? sxe_pkg::Q_MIN : sxe_pkg::Q_MAX;
        end
    end

    // One restoring divider step: shift in the next dividend bit and trial subtract.
    assign w_shift = {r_rem, r_dvd[QW-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_qbit  = !w_trial[DW];

    // Apply the quotient sign and saturate.
    always_comb begin
        if (r_neg) begin
            if (r_dvd > QW'(sxe_pkg::Q_MIN)) begin
                w_div_res = sxe_pkg::Q_MIN;
            end else begin
                w_div_res = ~r_dvd[DW-1:0] + DW'(1);
            end
        end else begin
            if (r_dvd[QW-1:DW-1] != '0) begin
                w_div_res = sxe_pkg::Q_MAX;
            end else begin
                w_div_res = r_dvd[DW-1:0];
            end
        end
    end

    // Control of the shared unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op)
                            sxe_pkg::OP_MUL: r_state <= A_MUL;
                            sxe_pkg::OP_DIV: r_state <= A_DIV;
                            default:         r_done  <= 1'b1;
                        endcase
                    end
                end
                A_MUL: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    if (r_cnt == CNW'(QW - 1)) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    // Datapath registers of the shared unit.
    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_prod   <= $signed(i_lhs) * $signed(i_rhs);
                    r_neg    <= i_lhs[DW-1] ^ i_rhs[DW-1];
                    r_dvd    <= {abs32(i_lhs), FW'(0)};
                    r_dvs    <= abs32(i_rhs);
                    r_rem    <= '0;
                    r_cnt    <= '0;
                    r_result <= (i_req.op == sxe_pkg::OP_SUB) ? sat33(w_diff) : sat33(w_sum);
                end
            end
            A_MUL: begin
                r_result <= w_mul_res;
            end
            A_DIV: begin
                r_rem <= w_qbit ? w_trial[DW-1:0] : w_shift[DW-1:0];
                r_dvd <= {r_dvd[QW-2:0], w_qbit};
                r_cnt <= r_cnt + CNW'(1);
            end
            A_FIN: begin
                r_result <= w_div_res;
            end
            default: r_result <= r_result;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> rtl/core/stack_expression_evaluator.sv
// Postfix / prefix expression evaluator on a bounded Q16.16 operand stack.
// Input channel (i_s_axis_*): one token per item. tuser carries the token
// kind in bits 2:0, tdata the Q16.16 number in bits 31:0 (used only by a
// number token), and tlast marks the last token of an expression.
// Output channel (o_m_axis_*): one item per expression, sent after its last
// token, with value in bits 31:0 and status in bits 34:32. i_cfg_we with
// i_cfg_wdata selects prefix order (1) or postfix order (0). The user must
// ensure it is written only between tokens; the block does not enforce it.
// Per token: a number is pushed; an operator reads both operands, runs the
// shared arithmetic unit and writes the result back. Divide uses the unit's
// restoring divider, which produces one of 48 quotient bits per cycle. A
// last token then loads the result register. The block takes one token at
// a time; tready is high only while the sequencer is idle.
// A finished result waits in the output register while new tokens are taken;
// only a further last token waits for the receiver to take the previous one.
// Reset (i_rst_n low at a clock edge) empties the stack, clears the error
// and the output valid flag, and selects postfix order. The stack memory
// itself is not cleared; entries are only read after being written.
module stack_expression_evaluator #(
    parameter int STACK_DEPTH = sxe_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // number [31:0]
    input  logic [2:0]  i_s_axis_tuser,   // op [2:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // value [31:0], status [34:32], zero fill
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int DW = sxe_pkg::DATA_W;
    localparam int OW = sxe_pkg::OP_W;
    localparam int SW = sxe_pkg::ST_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_err, n_err;
    logic [DW-1:0] r_bottom, n_bottom;
    logic [OW-1:0] r_op, n_op;
    logic          r_last, n_last;
    logic          r_prefix;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_value, n_out_value;
    logic [SW-1:0] r_out_status, n_out_status;

    logic          w_accept;
    logic [OW-1:0] w_in_op;
    logic [DW-1:0] w_in_num;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_re;
    logic [DW-1:0] w_top;
    logic [DW-1:0] w_next;
    logic [DW-1:0] w_lhs;
    logic [DW-1:0] w_rhs;
    logic          w_alu_done;
    logic [DW-1:0] w_alu_result;
    logic [1:0]    w_end_state;

    sxe_pkg::t_alu_req w_alu_req;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_op  = i_s_axis_tuser[OW-1:0];
    assign w_in_num = i_s_axis_tdata[DW-1:0];
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);

    // Operand order follows the selected notation.
    assign w_lhs = r_prefix ? w_top : w_next;
    assign w_rhs = r_prefix ? w_next : w_top;

    // Where a finished token goes: report on the last token, else wait for the next.
    assign w_end_state = r_last ? S_EMIT : S_IDLE;

    sxe_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_cnt_m1[AW-1:0]),
        .i_raddr_b (w_cnt_m2[AW-1:0]),
        .o_rdata_a (w_top),
        .o_rdata_b (w_next)
    );

    sxe_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_lhs    (w_lhs),
        .i_rhs    (w_rhs),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    // Sequencer: takes a token, fetches operands, runs the unit, writes back.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_err         = r_err;
        n_bottom      = r_bottom;
        n_op          = r_op;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        w_we          = 1'b0;
        w_waddr       = r_count[AW-1:0];
        w_wdata       = w_in_num;
        w_re          = 1'b0;
        w_alu_req     = '{start: 1'b0, op: r_op};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = w_in_op;
                    n_last = i_s_axis_tlast;
                    n_state = i_s_axis_tlast ? S_EMIT : S_IDLE;
                    if (r_err != sxe_pkg::ST_OK || w_in_op > sxe_pkg::OP_DIV) begin
                        // Error already set or unknown kind: the token changes nothing.
                    end else if (w_in_op == sxe_pkg::OP_NUM) begin
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_err = sxe_pkg::ST_OVERFLOW;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                n_bottom = w_in_num;
                            end
                        end
                    end else if (r_count < CW'(2)) begin
                        n_err = sxe_pkg::ST_UNDERFLOW;
                    end else begin
                        w_re    = 1'b1;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (r_op == sxe_pkg::OP_DIV && w_rhs == '0) begin
                    n_err   = sxe_pkg::ST_DIVZERO;
                    n_state = w_end_state;
                end else begin
                    w_alu_req.start = 1'b1;
                    n_state         = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_alu_done) begin
                    // Two operands popped, the result pushed in their place.
                    w_we    = 1'b1;
                    w_waddr = w_cnt_m2[AW-1:0];
                    w_wdata = w_alu_result;
                    n_count = w_cnt_m1;
                    if (w_cnt_m2 == '0) begin
                        n_bottom = w_alu_result;
                    end
                    n_state = w_end_state;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    if (r_err != sxe_pkg::ST_OK) begin
                        n_out_status = r_err;
                        n_out_value  = '0;
                    end else if (r_count != CW'(1)) begin
                        n_out_status = sxe_pkg::ST_NOT_ONE;
                        n_out_value  = '0;
                    end else begin
                        n_out_status = sxe_pkg::ST_OK;
                        n_out_value  = r_bottom;
                    end
                    n_count = '0;
                    n_err   = sxe_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= sxe_pkg::ST_OK;
            r_out_valid <= 1'b0;
            r_prefix    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_prefix <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bottom     <= n_bottom;
        r_op         <= n_op;
        r_last       <= n_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_status, r_out_value};

endmodule

>>> tb/sv/tb_stack_expression_evaluator.sv
module tb_stack_expression_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import sxe_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    // Cycles to let a token that yields no item finish (divide plus result load).
    localparam int SETTLE_CYCLES = 64;
    // Length of the one long receiver hold-off.
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_TOKENS = 360;
    localparam int MAX_PRINTED = 100;

    // Evaluation order of the mode register.
    localparam logic MODE_POSTFIX = 1'b0;
    localparam logic MODE_PREFIX  = 1'b1;

    // Token kinds the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd5;
    localparam logic [OP_W-1:0] OP_TOP    = 3'd7;

    localparam logic [DATA_W-1:0] Q_ONE32 = 32'h0001_0000;
    localparam longint Q_ONE  = longint'(1) << FRAC_W;
    localparam longint SAT_HI = longint'($signed(Q_MAX));
    localparam longint SAT_LO = longint'($signed(Q_MIN));

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ST_W-1:0]   status;
    } t_result;

    // One row of the directed sequence: a mode write or a token repeated rep times.
    typedef struct {
        logic              is_cfg;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] num;
        logic              last;
        int                rep;
        logic              typed;
        logic [DATA_W-1:0] value;
        logic [ST_W-1:0]   status;
    } t_plan_row;

    localparam int PLAN_LEN = 23;

    t_plan_row plan [PLAN_LEN] = '{
        '{1'b1, OP_NUM, 32'(MODE_POSTFIX), 1'b0, 1, 1'b0, 32'h0, ST_OK},
        // A lone extreme value after reset.
        '{1'b0, OP_NUM, 32'h7FFF_FFFF, 1'b1, 1, 1'b1, 32'h7FFF_FFFF, ST_OK},
        // Operator on an empty stack.
        '{1'b0, OP_SUB, 32'h0, 1'b1, 1, 1'b1, 32'h0, ST_UNDERFLOW},
        // An unused op code closes an empty expression.
        '{1'b0, OP_TOP, 32'h0, 1'b1, 1, 1'b1, 32'h0, ST_NOT_ONE},
        // Subtract and multiply both saturate low; the unused op is skipped.
        '{1'b0, OP_NUM, 32'h8000_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0001_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_SUB, 32'h0, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0002_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_MUL, 32'h0, 1'b1, 1, 1'b1, 32'h8000_0000, ST_OK},
        // Divide by zero sticks; the add after it is ignored.
        '{1'b0, OP_NUM, 32'h0003_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_DIV, 32'h0, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_ADD, 32'h0, 1'b1, 1, 1'b1, 32'h0, ST_DIVZERO},
        // Fill the stack and push once more.
        '{1'b0, OP_NUM, 32'h0000_8000, 1'b0, DEPTH, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0000_0001, 1'b1, 1, 1'b1, 32'h0, ST_OVERFLOW},
        // Prefix divide, then the mode flips in the middle of the expression.
        '{1'b1, OP_NUM, 32'(MODE_PREFIX), 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0002_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0008_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_DIV, 32'h0, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b1, OP_NUM, 32'(MODE_POSTFIX), 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_NUM, 32'h0003_0000, 1'b0, 1, 1'b0, 32'h0, ST_OK},
        '{1'b0, OP_ADD, 32'h0, 1'b1, 1, 1'b0, 32'h0, ST_OK}
    };

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [31:0]       i_s_axis_tdata  = '0;   // number [31:0]
    logic [2:0]        i_s_axis_tuser  = '0;   // op [2:0]
    logic              i_s_axis_tlast  = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [39:0]       o_m_axis_tdata;         // value [31:0], status [34:32], zero fill
    logic              i_cfg_we        = 1'b0;
    logic              i_cfg_wdata     = 1'b0;

    // Predicted state of the evaluator.
    logic signed [DATA_W-1:0] calc_stack [DEPTH];
    int                       calc_count  = 0;
    logic [ST_W-1:0]          calc_error  = ST_OK;
    logic                     calc_prefix = MODE_POSTFIX;

    t_result expected_results [$];
    int      mismatches   = 0;
    int      tokens_taken = 0;
    int      burst_left   = 0;
    bit      burst_quiet  = 1'b0;

    // Receiver stall state.
    logic        long_hold_go    = 1'b0;
    logic        long_hold_taken = 1'b0;
    int          hold_left       = 0;
    logic [31:0] rx_cycle        = '0;
    int          rx_style        = 0;

    stack_expression_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Applies one accepted token to the predicted stack and returns 1 when it
    // closes an expression, with the item the block must send for it.
    function automatic bit eval_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] num,
                                      input logic last, output t_result res);
        longint lhs, rhs, acc;
        lhs = 0;
        rhs = 0;
        acc = 0;
        res = '0;
        if (calc_error == ST_OK && op <= OP_DIV) begin
            if (op == OP_NUM) begin
                if (calc_count >= DEPTH) begin
                    calc_error = ST_OVERFLOW;
                end else begin
                    calc_stack[calc_count] = num;
                    calc_count++;
                end
            end else if (calc_count < 2) begin
                calc_error = ST_UNDERFLOW;
            end else begin
                // Postfix pops the right operand first, prefix the left one.
                if (calc_prefix) begin
                    lhs = calc_stack[calc_count-1];
                    rhs = calc_stack[calc_count-2];
                end else begin
                    lhs = calc_stack[calc_count-2];
                    rhs = calc_stack[calc_count-1];
                end
                case (op)
                    OP_ADD: acc = lhs + rhs;
                    OP_SUB: acc = lhs - rhs;
                    OP_MUL: acc = (lhs * rhs) / Q_ONE;
                    default: begin
                        if (rhs == 0) calc_error = ST_DIVZERO;
                        else acc = (lhs * Q_ONE) / rhs;
                    end
                endcase
                if (calc_error == ST_OK) begin
                    if (acc > SAT_HI) acc = SAT_HI;
                    else if (acc < SAT_LO) acc = SAT_LO;
                    calc_stack[calc_count-2] = acc[DATA_W-1:0];
                    calc_count--;
                end
            end
        end
        if (!last) return 1'b0;
        if (calc_error != ST_OK) res.status = calc_error;
        else if (calc_count != 1) res.status = ST_NOT_ONE;
        else begin
            res.status = ST_OK;
            res.value  = calc_stack[0];
        end
        calc_count = 0;
        calc_error = ST_OK;
        return 1'b1;
    endfunction

    // Mix of extremes, small values around zero and full-range words.
    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE32;
                    default: return -Q_ONE32;
                endcase
            end
            1, 2, 3: return DATA_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Offers one token in bursts with random gaps and predicts on acceptance.
    task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] num,
                              input logic last, input logic typed, input t_result typed_res);
        int gap;
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = burst_quiet ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= num;
        i_s_axis_tuser  <= op;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tokens_taken++;
        if (eval_token(op, num, last, res))
            expected_results.insert(expected_results.size(), typed ? typed_res : res);
    endtask

    // Writes the mode once every item has come out and the block has settled.
    task automatic write_mode(input logic prefix);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= prefix;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        calc_prefix = prefix;
    endtask

    // One expression: mostly well formed, some deep enough to overflow, some noise.
    task automatic gen_expression();
        int kind, operands, depth, i, n;
        logic [OP_W-1:0] op;
        logic last;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // Noise may use the unused codes and may leave the expression open.
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                op = OP_W'($urandom_range(OP_NUM, OP_TOP));
                last = (i == n - 1) && ($urandom_range(0, 3) != 0);
                send_token(op, rand_q16(), last, 1'b0, '0);
            end
        end else begin
            operands = (kind == 1) ? $urandom_range(DEPTH - 2, DEPTH + 2) : $urandom_range(1, 6);
            depth = 0;
            while (operands > 0 || depth > 1) begin
                if (depth < 2 || (operands > 0 && (kind == 1 || $urandom_range(0, 1) == 1))) begin
                    op = OP_NUM;
                    operands--;
                    depth++;
                end else begin
                    op = OP_W'($urandom_range(OP_ADD, OP_DIV));
                    depth--;
                end
                last = (operands == 0 && depth == 1);
                send_token(op, rand_q16(), last, 1'b0, '0);
            end
        end
    endtask

    // Receiver: a stall style that is redrawn at random, plus one long hold.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0) rx_style <= $urandom_range(0, 2);
        if (long_hold_go && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                default: i_m_axis_tready <= (rx_cycle[1:0] == 2'b00);
            endcase
        end
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", o_m_axis_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.value)
                    report_mismatch("value", o_m_axis_tdata[31:0], want.value);
                if (o_m_axis_tdata[34:32] !== want.status)
                    report_mismatch("status", 32'(o_m_axis_tdata[34:32]), 32'(want.status));
            end
        end
    end

    initial begin
        #800000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int r, k, phase, start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence.
        for (r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].is_cfg) begin
                write_mode(plan[r].num[0]);
            end else begin
                for (k = 0; k < plan[r].rep; k++)
                    send_token(plan[r].op, plan[r].num, plan[r].last && (k == plan[r].rep - 1),
                               plan[r].typed, '{value: plan[r].value, status: plan[r].status});
            end
        end

        // Random phases, each with its own mode and sender pacing.
        start = tokens_taken;
        phase = 0;
        while (tokens_taken - start < RANDOM_TOKENS) begin
            write_mode(logic'($urandom_range(0, 1)));
            burst_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Keep offering tokens while the receiver holds off.
                burst_quiet = 1'b1;
                long_hold_go <= 1'b1;
            end
            for (k = 0; k < 6; k++) gen_expression();
            phase++;
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
